// ===== hw/rtl/pip_pkg.sv =====
`default_nettype none

package pip_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF   = 16;

    // Result transfer layout, lowest bit first:
    // inside_res, on_boundary, store_full, vertices_held, zero pad
    localparam int HELD_W      = 7;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 3 - HELD_W;

    // Item kinds carried on s_axis_tuser
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } pip_state_t;

    // Per-edge verdict from the edge test pipeline
    typedef struct packed {
        logic valid;
        logic hit;
        logic on_point;
    } pip_edge_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pip_edge_unit.sv =====
`default_nettype none

module pip_edge_unit
    import pip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    input  wire signed [COORD_BITS-1:0]  x1,
    input  wire signed [COORD_BITS-1:0]  y1,
    input  wire signed [COORD_BITS-1:0]  x2,
    input  wire signed [COORD_BITS-1:0]  y2,
    input  wire signed [COORD_BITS-1:0]  px,
    input  wire signed [COORD_BITS-1:0]  py,
    input  wire signed [COORD_BITS-1:0]  lo_x,
    input  wire signed [COORD_BITS-1:0]  hi_x,
    output logic                         busy,
    output pip_edge_res_t                res
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // Stage A: differences against the edge start
    logic                 va_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, pd_reg, lx_reg, hx_reg, pxd_reg;

    // Stage B: products and the row range check
    logic                 vb_reg;
    logic                 neg_reg;
    logic                 ok_reg;
    logic signed [PW-1:0] num_reg, plo_reg, phi_reg, ppt_reg;

    pip_edge_res_t        res_reg;

    logic                 in_range;
    logic                 outside;
    logic                 crossing;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            res_reg <= '0;
        end else begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            res_reg.valid <= vb_reg;
            res_reg.hit   <= vb_reg & crossing;
            res_reg.on_point <= vb_reg & crossing & (num_reg == ppt_reg);
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= DW'(x2)   - DW'(x1);
        dy_reg  <= DW'(y2)   - DW'(y1);
        pd_reg  <= DW'(py)   - DW'(y1);
        lx_reg  <= DW'(lo_x) - DW'(x1);
        hx_reg  <= DW'(hi_x) - DW'(x1);
        pxd_reg <= DW'(px)   - DW'(x1);
    end

    // A falling edge mirrors the row test instead of negating operands
    always_comb begin
        if (dy_reg < 0) begin
            in_range = (pd_reg <= 0) && (pd_reg >= dy_reg);
        end else begin
            in_range = (pd_reg >= 0) && (pd_reg <= dy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= dy_reg < 0;
        ok_reg  <= (dy_reg != 0) && in_range;
        num_reg <= PW'(dx_reg)  * PW'(pd_reg);
        plo_reg <= PW'(lx_reg)  * PW'(dy_reg);
        phi_reg <= PW'(hx_reg)  * PW'(dy_reg);
        ppt_reg <= PW'(pxd_reg) * PW'(dy_reg);
    end

    // Stage C: bound compares, direction flipped for a falling edge
    always_comb begin
        if (neg_reg) begin
            outside = (num_reg > plo_reg) || (num_reg < phi_reg);
        end else begin
            outside = (num_reg < plo_reg) || (num_reg > phi_reg);
        end
        crossing = ok_reg && !outside;
    end

    assign busy = va_reg | vb_reg | res_reg.valid;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/polygon_point_inside_test.sv =====
`default_nettype none

// Channel   Ports       Transfer contents (lowest bit first)
// -------   ---------   ------------------------------------------------------
// input     s_axis_*    tuser: operation; tdata: coord_x, coord_y, zero pad
// result    m_axis_*    tdata: inside_res, on_boundary, store_full,
//                       vertices_held, zero pad
//
// An append, or a query with fewer than two vertices or x on the east bound, skips
// the walk and goes from the accept to loading the result. A query with N vertices
// makes N + 1 vertex reads (closing edge included), drains the read register and
// three-stage edge test until both are empty, then loads the result.
// aresetn clears count, east bound and control, not the vertex memory. A stalled
// result holds in the output register; the next item is worked on, then holds too.

module polygon_point_inside_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  wire                                         aclk,
    input  wire                                         aresetn,

    input  wire                                         s_axis_tvalid,
    output logic                                        s_axis_tready,
    // coord_x, coord_y, zero pad
    input  wire [((2 * COORD_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,
    // operation
    input  wire                                         s_axis_tuser,

    output logic                                        m_axis_tvalid,
    input  wire                                         m_axis_tready,
    // inside_res, on_boundary, store_full, vertices_held, zero pad
    output logic [OUT_TDATA_W-1:0]                      m_axis_tdata
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int VW     = 2 * COORD_BITS;

    pip_state_t                     state_reg, state_next;

    logic [CNT_W-1:0]               total_reg, total_next;
    logic signed [COORD_BITS-1:0]   east_reg, east_next;
    logic signed [COORD_BITS-1:0]   px_reg, px_next;
    logic signed [COORD_BITS-1:0]   py_reg, py_next;
    logic signed [COORD_BITS-1:0]   lo_reg, lo_next;
    logic signed [COORD_BITS-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]               rd_cnt_reg, rd_cnt_next;
    logic                           rdv_reg;
    logic                           rd_first_reg;
    logic [VW-1:0]                  rd_data_reg;
    logic [VW-1:0]                  prev_reg;
    logic                           parity_reg, parity_next;
    logic                           onb_reg, onb_next;
    logic                           full_reg, full_next;
    logic                           m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]         m_data_reg, m_data_next;

    // Vertex memory, one entry holds {y, x}
    logic [VW-1:0]                  vmem [MAX_VERTICES];

    logic                           accept;
    logic signed [COORD_BITS-1:0]   in_x;
    logic signed [COORD_BITS-1:0]   in_y;
    logic                           mem_we;
    logic                           rd_en;
    logic                           rd_last;
    logic [ADDR_W-1:0]              rd_addr;
    logic                           out_free;

    logic                           edge_busy;
    pip_edge_res_t                  edge_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign in_x          = s_axis_tdata[COORD_BITS-1:0];
    assign in_y          = s_axis_tdata[VW-1:COORD_BITS];

    // Append writes at the fill count; a full store drops the vertex
    assign mem_we = accept && (s_axis_tuser == OP_APPEND)
                    && (total_reg != CNT_W'(MAX_VERTICES));

    // Walk reads vertices 0 .. N-1, then vertex 0 again for the closing edge
    assign rd_en   = (state_reg == ST_WALK);
    assign rd_last = (rd_cnt_reg == total_reg);
    assign rd_addr = rd_last ? '0 : rd_cnt_reg[ADDR_W-1:0];

    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vmem[total_reg[ADDR_W-1:0]] <= {in_y, in_x};
        end
        if (rd_en) begin
            rd_data_reg <= vmem[rd_addr];
        end
    end

    // Consecutive reads form an edge: previous vertex to the one just read
    always_ff @(posedge aclk) begin
        if (rdv_reg) begin
            prev_reg <= rd_data_reg;
        end
    end

    pip_edge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rdv_reg & ~rd_first_reg),
        .x1       (prev_reg[COORD_BITS-1:0]),
        .y1       (prev_reg[VW-1:COORD_BITS]),
        .x2       (rd_data_reg[COORD_BITS-1:0]),
        .y2       (rd_data_reg[VW-1:COORD_BITS]),
        .px       (px_reg),
        .py       (py_reg),
        .lo_x     (lo_reg),
        .hi_x     (hi_reg),
        .busy     (edge_busy),
        .res      (edge_res)
    );

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        east_next    = east_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        rd_cnt_next  = rd_cnt_reg;
        parity_next  = parity_reg;
        onb_next     = onb_reg;
        full_next    = full_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        // Drop the output once the sink takes it
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        // Fold each edge verdict into the crossing parity and the boundary flag
        if (edge_res.valid) begin
            parity_next = parity_reg ^ (edge_res.hit & ~edge_res.on_point);
            onb_next    = onb_reg | edge_res.on_point;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    parity_next = 1'b0;
                    onb_next    = 1'b0;
                    full_next   = 1'b0;
                    state_next  = ST_FINISH;
                    if (s_axis_tuser == OP_APPEND) begin
                        if (mem_we) begin
                            total_next = total_reg + CNT_W'(1);
                            if ((total_reg == '0) || (in_x > east_reg)) begin
                                east_next = in_x;
                            end
                        end else begin
                            full_next = 1'b1;
                        end
                    end else if ((total_reg >= CNT_W'(2)) && (in_x != east_reg)) begin
                        px_next     = in_x;
                        py_next     = in_y;
                        lo_next     = (in_x < east_reg) ? in_x : east_reg;
                        hi_next     = (in_x < east_reg) ? east_reg : in_x;
                        rd_cnt_next = '0;
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (rd_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!rdv_reg && !edge_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // Hold the result until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{OUT_PAD_W{1'b0}}, HELD_W'(total_reg), full_reg,
                                    onb_reg, parity_reg & ~onb_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            east_reg     <= '0;
            rdv_reg      <= 1'b0;
            rd_first_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            east_reg     <= east_next;
            rdv_reg      <= rd_en;
            rd_first_reg <= rd_en && (rd_cnt_reg == '0);
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        rd_cnt_reg <= rd_cnt_next;
        parity_reg <= parity_next;
        onb_reg    <= onb_next;
        full_reg   <= full_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== bench/tb_polygon_point_inside_test.sv =====
`timescale 1ns / 1ps

module tb_polygon_point_inside_test;
    import pip_pkg::*;

    // The polygon only ever grows, because only reset empties it and reset
    // comes once. The run therefore works through three stages:
    //   - a directed opening that builds a small triangle by hand and probes it,
    //   - a random stretch where vertices trickle in between many queries until
    //     the store is full,
    //   - further queries and dropped appends against the full 64-vertex polygon.
    // Every accepted input transfer updates a local mirror of the polygon and
    // predicts the result. Every result transfer is checked against the oldest
    // prediction, field by field.

    localparam int CW        = COORD_BITS_DEF;
    localparam int IN_W      = ((2 * CW + 7) / 8) * 8;
    localparam int N_RANDOM  = 800;
    localparam int LIMIT     = 600_000;

    // Result transfer fields, declared so that the packed layout matches
    // m_axis_tdata from the lowest bit up: inside_res first.
    typedef struct packed {
        logic [HELD_W-1:0] held;
        logic              store_full;
        logic              on_boundary;
        logic              inside_res;
    } verdict_t;

    // How one polygon edge meets the cast segment.
    typedef enum int { MISS, HIT, HIT_ON_POINT } crossing_t;

    // Polygon mirror, result predictor and result checker.
    class pip_scoreboard;
        logic signed [CW-1:0] vx [MAX_VERTICES_DEF];
        logic signed [CW-1:0] vy [MAX_VERTICES_DEF];
        int unsigned          held;
        logic signed [CW-1:0] east;
        verdict_t             pending [$];
        int unsigned          fail_count, appends, drops, queries, insides, boundaries;

        function new();
            held = 0;
            east = '0;
        endfunction

        // Exact crossing test of edge (x1,y1)-(x2,y2) against the horizontal
        // segment lo..hi at height py. Products stay well inside 64 bits.
        function crossing_t edge_crossing(longint x1, longint y1, longint x2, longint y2,
                                          longint px, longint py, longint lo, longint hi);
            longint dy, pd, num;
            dy = y2 - y1;
            pd = py - y1;
            if (dy == 0)
                return MISS;
            if (dy < 0) begin
                dy = -dy;
                pd = -pd;
            end
            if (pd < 0 || pd > dy)
                return MISS;
            num = (x2 - x1) * pd;
            if (num < (lo - x1) * dy)
                return MISS;
            if (num > (hi - x1) * dy)
                return MISS;
            if (num == (px - x1) * dy)
                return HIT_ON_POINT;
            return HIT;
        endfunction

        // Apply one accepted input transfer and queue the result it must give.
        function void note_item(logic op, logic signed [CW-1:0] x, logic signed [CW-1:0] y);
            verdict_t    v;
            longint      px, py, lo, hi;
            int unsigned hits;
            int unsigned j;
            crossing_t   c;
            v  = '0;
            px = x;
            py = y;
            if (op == OP_APPEND) begin
                appends++;
                if (held >= MAX_VERTICES_DEF) begin
                    v.store_full = 1'b1;
                    drops++;
                end else begin
                    vx[held] = x;
                    vy[held] = y;
                    if (held == 0 || x > east)
                        east = x;
                    held++;
                end
            end else begin
                queries++;
                if (held >= 2 && x != east) begin
                    lo   = (px < east) ? px : east;
                    hi   = (px < east) ? east : px;
                    hits = 0;
                    for (int unsigned i = 0; i < held; i++) begin
                        j = (i + 1 == held) ? 0 : i + 1;
                        c = edge_crossing(vx[i], vy[i], vx[j], vy[j], px, py, lo, hi);
                        if (c == HIT_ON_POINT) begin
                            v.on_boundary = 1'b1;
                            break;
                        end
                        if (c == HIT)
                            hits++;
                    end
                    if (!v.on_boundary)
                        v.inside_res = hits[0];
                end
                insides    += v.inside_res;
                boundaries += v.on_boundary;
            end
            v.held = HELD_W'(held);
            pending = {pending, v};
        endfunction

        // Compare one result transfer with the oldest prediction.
        function void check_result(logic [OUT_TDATA_W-1:0] data);
            verdict_t want, got;
            got = verdict_t'(data[HELD_W+2:0]);
            if (pending.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", data);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            if (got.inside_res !== want.inside_res) begin
                $error("inside_res: expected %0d, got %0d", want.inside_res, got.inside_res);
                fail_count++;
            end
            if (got.on_boundary !== want.on_boundary) begin
                $error("on_boundary: expected %0d, got %0d", want.on_boundary, got.on_boundary);
                fail_count++;
            end
            if (got.store_full !== want.store_full) begin
                $error("store_full: expected %0d, got %0d", want.store_full, got.store_full);
                fail_count++;
            end
            if (got.held !== want.held) begin
                $error("vertices_held: expected %0d, got %0d", want.held, got.held);
                fail_count++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;   // coord_x, coord_y, zero pad
    logic                   s_axis_tuser;   // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // inside_res, on_boundary, store_full,
                                            // vertices_held, zero pad

    pip_scoreboard sb;
    int            burst_left = 0;
    int            cycles     = 0;
    int            long_holds = 0;
    bit            hold_req   = 1'b0;

    polygon_point_inside_test uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Guard against a hung block.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending.size());
            $display("[polygon_point_inside_test] ERROR");
            $finish;
        end
    end

    // Observe both channels on the clock edge; values seen here are the ones
    // the block sampled, so prediction follows the real acceptance order.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_item(s_axis_tuser, s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW]);
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Offer one item and hold it until the transfer. Items go out in bursts;
    // a gap opens only between bursts, and valid drops only when a gap opens
    // so it is never lowered and raised in one step.
    task automatic send_item(input logic op, input logic [CW-1:0] x, input logic [CW-1:0] y);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({y, x});
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        burst_left--;
    endtask

    // Result side: its own stall pattern, switching between always ready,
    // coin-flip ready, a fixed one-in-three stall and rare stalls. On request
    // hold off for a long stretch so the block fills and blocks its input.
    initial begin
        int mode, len, tick;
        tick = 0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_holds++;
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(4, 60);
            repeat (len) begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (tick % 3 != 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
                tick++;
                @(posedge aclk);
            end
        end
    end

    initial begin
        logic [CW-1:0] qx, qy;
        int            k, i, j, sel;

        sb            = new();
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_APPEND;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening: empty polygon, single vertex, two-vertex segment
        // (walked twice), then a triangle with a horizontal closing edge.
        send_item(OP_QUERY,  16'sd0,      16'sd0);
        send_item(OP_QUERY,  16'h8000,    16'h7fff);
        send_item(OP_APPEND, 16'sd100,    16'sd50);
        send_item(OP_QUERY,  16'sd0,      16'sd50);      // one vertex: no edges
        send_item(OP_APPEND, 16'sd200,    16'sd150);
        send_item(OP_QUERY,  16'sd150,    16'sd100);     // on the lone segment
        send_item(OP_QUERY,  16'sd120,    16'sd100);     // segment counted twice
        send_item(OP_APPEND, 16'sd300,    16'sd50);
        send_item(OP_QUERY,  16'sd200,    16'sd80);      // inside the triangle
        send_item(OP_QUERY,  16'sd50,     16'sd80);      // west, two crossings
        send_item(OP_QUERY,  16'sd200,    16'sd50);      // on the horizontal edge
        send_item(OP_QUERY,  16'sd300,    16'sd80);      // zero-length segment
        send_item(OP_QUERY,  16'sd400,    16'sd80);      // east of the bound
        send_item(OP_QUERY,  16'h7fff,    16'sd60);
        send_item(OP_QUERY,  16'sd200,    16'sd150);     // exactly on a vertex
        send_item(OP_QUERY,  16'h8000,    16'h8000);
        send_item(OP_QUERY,  16'h7fff,    16'h7fff);
        send_item(OP_APPEND, 16'h8000,    16'h8000);
        send_item(OP_QUERY,  16'sd0,      16'sd0);
        send_item(OP_APPEND, 16'h8000,    16'h7fff);
        send_item(OP_QUERY,  16'hffff,    16'hffff);

        // Random stretch: vertices arrive now and then, queries aim mostly at
        // vertices, their heights, edge midpoints and the east bound.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 40 || n == 560)
                hold_req = 1'b1;
            k = sb.held;
            if ($urandom_range(0, (k < MAX_VERTICES_DEF) ? 6 : 15) == 0) begin
                sel = $urandom_range(0, 19);
                if (k == MAX_VERTICES_DEF - 1) begin
                    // last free slot: push the east bound to the top
                    qx = 16'h7fff;
                    qy = CW'($urandom);
                end else if (sel < 2) begin
                    qx = CW'($urandom);
                    qy = CW'($urandom);
                end else if (sel < 5 && k > 0) begin
                    // share a height with an existing vertex
                    i  = $urandom_range(0, k - 1);
                    qy = sb.vy[i];
                    qx = CW'($urandom_range(0, 8000) - 4000);
                end else if (sel == 5 && k > 0) begin
                    // repeat the last vertex: degenerate edge
                    qx = sb.vx[k-1];
                    qy = sb.vy[k-1];
                end else begin
                    qx = CW'($urandom_range(0, 8000) - 4000);
                    qy = CW'($urandom_range(0, 8000) - 4000);
                end
                send_item(OP_APPEND, qx, qy);
            end else begin
                sel = (k == 0) ? 6 : $urandom_range(0, 9);
                i   = (k == 0) ? 0 : $urandom_range(0, k - 1);
                j   = (i + 1 == k) ? 0 : i + 1;
                case (sel)
                    0, 1: begin
                        qx = sb.vx[i];
                        qy = sb.vy[i];
                    end
                    2, 3: begin
                        qy = sb.vy[i];
                        qx = CW'(sb.vx[i] + $urandom_range(0, 256) - 128);
                    end
                    4: begin
                        qx = CW'((int'(sb.vx[i]) + int'(sb.vx[j])) >>> 1);
                        qy = CW'((int'(sb.vy[i]) + int'(sb.vy[j])) >>> 1);
                    end
                    5: begin
                        qx = sb.east;
                        qy = CW'(sb.vy[i] + $urandom_range(0, 64) - 32);
                    end
                    6: begin
                        qx = CW'($urandom);
                        qy = CW'($urandom);
                    end
                    default: begin
                        qx = CW'($urandom_range(0, 10000) - 5000);
                        qy = CW'($urandom_range(0, 10000) - 5000);
                    end
                endcase
                send_item(OP_QUERY, qx, qy);
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);

        // Drain, then allow the longest query time for anything stray.
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (MAX_VERTICES_DEF + 40) @(posedge aclk);

        $display("covered %0d appends (%0d dropped on a full store) and %0d queries",
                 sb.appends, sb.drops, sb.queries);
        $display("queries inside %0d, on an edge %0d; long output stalls %0d",
                 sb.insides, sb.boundaries, long_holds);
        if (sb.fail_count == 0)
            $display("[polygon_point_inside_test] OK");
        else
            $display("[polygon_point_inside_test] ERROR");
        $finish;
    end

endmodule

// ===== polygon_point_inside_test.f =====
hw/rtl/pip_pkg.sv
hw/rtl/pip_edge_unit.sv
hw/rtl/polygon_point_inside_test.sv
bench/tb_polygon_point_inside_test.sv
